// ----- src/swt_pkg.sv -----
// shared types and constants for the shell word tokenizer
// no dependencies
package swt_pkg;

	localparam int ChW = 8;

	localparam logic [ChW-1:0] C_SQUOTE = 8'h27;
	localparam logic [ChW-1:0] C_DQUOTE = 8'h22;
	localparam logic [ChW-1:0] C_BSLASH = 8'h5C;
	localparam logic [ChW-1:0] C_DOLLAR = 8'h24;
	localparam logic [ChW-1:0] C_BTICK  = 8'h60;
	localparam logic [ChW-1:0] C_SPACE  = 8'h20;
	localparam logic [ChW-1:0] C_TAB    = 8'h09;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		M_PLAIN = 3'd0,
		M_SQ    = 3'd1,
		M_DQ    = 3'd2,
		M_DQ_BS = 3'd3,
		M_BS    = 3'd4
	} mode_t;

	typedef struct packed {
		logic           kind;
		logic [ChW-1:0] ch;
	} res_t;

	// decoder verdict for one request
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
		mode_t      mode;
		logic       in_word;
	} dec_t;

endpackage

// ----- src/swt_decode.sv -----
// next-state and result decode for one request of the tokenizer
// depends on swt_pkg
module swt_decode (
	input  logic [swt_pkg::ChW-1:0] ch,
	input  logic                    is_end,
	input  swt_pkg::mode_t          mode,
	input  logic                    in_word,
	output swt_pkg::dec_t           dec
);

	swt_pkg::res_t lit_c, lit_bs, word_end;

	assign lit_c    = '{kind: swt_pkg::KIND_CHAR, ch: ch};
	assign lit_bs   = '{kind: swt_pkg::KIND_CHAR, ch: swt_pkg::C_BSLASH};
	assign word_end = '{kind: swt_pkg::KIND_END, ch: '0};

	always_comb begin
		dec.n       = 2'd0;
		dec.r0      = lit_c;
		dec.r1      = word_end;
		dec.mode    = mode;
		dec.in_word = in_word;
		if (is_end) begin
			dec.mode    = swt_pkg::M_PLAIN;
			dec.in_word = 1'b0;
			if (mode == swt_pkg::M_DQ_BS || mode == swt_pkg::M_BS) begin
				// pending backslash flushes as a literal, then the word ends
				dec.n  = 2'd2;
				dec.r0 = lit_bs;
				dec.r1 = word_end;
			end else if (in_word) begin
				dec.n  = 2'd1;
				dec.r0 = word_end;
			end
		end else begin
			unique case (mode)
				swt_pkg::M_SQ: begin
					if (ch == swt_pkg::C_SQUOTE) begin
						dec.mode = swt_pkg::M_PLAIN;
					end else begin
						dec.n = 2'd1;
					end
				end
				swt_pkg::M_DQ: begin
					if (ch == swt_pkg::C_DQUOTE) begin
						dec.mode = swt_pkg::M_PLAIN;
					end else if (ch == swt_pkg::C_BSLASH) begin
						dec.mode = swt_pkg::M_DQ_BS;
					end else begin
						dec.n = 2'd1;
					end
				end
				swt_pkg::M_DQ_BS: begin
					dec.mode = swt_pkg::M_DQ;
					if (ch == swt_pkg::C_DQUOTE || ch == swt_pkg::C_BSLASH
							|| ch == swt_pkg::C_DOLLAR || ch == swt_pkg::C_BTICK) begin
						dec.n = 2'd1;
					end else begin
						dec.n  = 2'd2;
						dec.r0 = lit_bs;
						dec.r1 = lit_c;
					end
				end
				swt_pkg::M_BS: begin
					dec.n       = 2'd1;
					dec.in_word = 1'b1;
					dec.mode    = swt_pkg::M_PLAIN;
				end
				default: begin
					dec.mode = swt_pkg::M_PLAIN;
					if (ch == swt_pkg::C_SQUOTE) begin
						dec.in_word = 1'b1;
						dec.mode    = swt_pkg::M_SQ;
					end else if (ch == swt_pkg::C_DQUOTE) begin
						dec.in_word = 1'b1;
						dec.mode    = swt_pkg::M_DQ;
					end else if (ch == swt_pkg::C_BSLASH) begin
						dec.in_word = 1'b1;
						dec.mode    = swt_pkg::M_BS;
					end else if (ch == swt_pkg::C_SPACE || ch == swt_pkg::C_TAB) begin
						dec.in_word = 1'b0;
						if (in_word) begin
							dec.n  = 2'd1;
							dec.r0 = word_end;
						end
					end else begin
						dec.n       = 2'd1;
						dec.in_word = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ----- src/swt_res_buf.sv -----
// two-slot result register, drained one result per cycle while the receiver does not stall
// depends on swt_pkg
module swt_res_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [1:0]              push_n,
	input  swt_pkg::res_t           push_r0,
	input  swt_pkg::res_t           push_r1,
	output logic                    free,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic                    kind,
	output logic [swt_pkg::ChW-1:0] ch_res,
	output logic                    last
);

	logic          valid_q;
	logic          ptr_q;
	logic          two_q;
	swt_pkg::res_t r0_q, r1_q;
	logic          take;
	logic          cur_last;

	assign cur_last  = ptr_q || !two_q;
	assign take      = valid_q && !rsp_stall;
	assign free      = !valid_q || (take && cur_last);
	assign rsp_valid = valid_q;
	assign kind      = ptr_q ? r1_q.kind : r0_q.kind;
	assign ch_res    = ptr_q ? r1_q.ch : r0_q.ch;
	assign last      = cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= 1'b0;
			two_q   <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
			ptr_q   <= 1'b0;
			two_q   <= (push_n == 2'd2);
		end else if (take) begin
			if (cur_last) begin
				valid_q <= 1'b0;
			end
			ptr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			r0_q <= push_r0;
			r1_q <= push_r1;
		end
	end

endmodule

// ----- src/shell_word_tokenizer.sv -----
// top level of the shell word tokenizer: request register, decode, result buffer
// depends on swt_pkg, swt_decode, swt_res_buf
//
// usage
//   request channel: req_valid / req_stall with ch and is_end; one byte of the
//   command line per request, then one request with is_end high that flushes
//   any open word and returns the tokenizer to between-words
//   result channel: rsp_valid / rsp_stall with kind, ch_res, last; kind 0 is a
//   word character, kind 1 marks the end of a word; last flags the final
//   result caused by one request
// an accepted request is decoded from the request register into the result buffer
// throughput: one request per cycle while the buffer can take the results; a
//   request that yields two results (a backslash before an ordinary byte in
//   double quotes, or a pending backslash at the end marker) holds the
//   two-slot result buffer until both are drained, which can stall the request
//   side; requests with no result pass without touching the buffer
// reset: arst_n clears the request register, the result buffer and the
//   quoting state (between words, no open word)
// receiver stall: the current result holds; the request register holds its
//   request and req_stall rises as soon as the buffer cannot take its results
module shell_word_tokenizer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [swt_pkg::ChW-1:0] ch,
	input  logic                    is_end,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic                    kind,
	output logic [swt_pkg::ChW-1:0] ch_res,
	output logic                    last
);

	// request register
	logic                    valid_s1;
	logic [swt_pkg::ChW-1:0] ch_s1;
	logic                    is_end_s1;

	// quoting state
	swt_pkg::mode_t mode_q;
	logic           in_word_q;

	swt_pkg::dec_t dec;
	logic          buf_free;
	logic          advance;
	logic          accept;

	swt_decode u_decode (
		.ch      (ch_s1),
		.is_end  (is_end_s1),
		.mode    (mode_q),
		.in_word (in_word_q),
		.dec     (dec)
	);

	// a request with no result retires regardless of the buffer
	assign advance   = valid_s1 && (dec.n == 2'd0 || buf_free);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	swt_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && dec.n != 2'd0),
		.push_n    (dec.n),
		.push_r0   (dec.r0),
		.push_r1   (dec.r1),
		.free      (buf_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.kind      (kind),
		.ch_res    (ch_res),
		.last      (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			mode_q    <= swt_pkg::M_PLAIN;
			in_word_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q    <= dec.mode;
				in_word_q <= dec.in_word;
			end
		end
	end

	// payload of the request register
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1     <= ch;
			is_end_s1 <= is_end;
		end
	end

endmodule
